// ----- src/swal_pkg.sv -----
// Package for the shortest all-letters window block.
// Holds the controller states, datapath operation codes and the
// command and status structs. It depends on nothing else.
`timescale 1ns / 1ps

package swal_pkg;

    localparam int LETTER_W = 5;
    localparam int OUT_LEN_W = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_R_RD,
        ST_R_CNT,
        ST_R_UPD,
        ST_L_CHK,
        ST_L_RD,
        ST_L_UPD
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_INIT,
        OP_RD_RIGHT,
        OP_RD_CNT,
        OP_INC,
        OP_SHRINK,
        OP_DEC,
        OP_NEXT_R,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic len_zero;
        logic covered_all;
        logic right_at_end;
    } t_dp_stat;

endpackage

// ----- src/swal_ctrl.sv -----
// Controller state machine for the shortest all-letters window block.
// Sequences loading and the two-pointer scan; uses swal_pkg.
`timescale 1ns / 1ps

module swal_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_is_last,
    input  swal_pkg::t_dp_stat i_stat,
    output swal_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    swal_pkg::t_state r_state;
    swal_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swal_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swal_pkg::ST_IDLE: begin
                if (i_start && i_is_last) begin
                    n_state = swal_pkg::ST_INIT;
                end
            end
            swal_pkg::ST_INIT: begin
                // An empty string goes straight to the result.
                n_state = i_stat.len_zero ? swal_pkg::ST_IDLE : swal_pkg::ST_R_RD;
            end
            swal_pkg::ST_R_RD:  n_state = swal_pkg::ST_R_CNT;
            swal_pkg::ST_R_CNT: n_state = swal_pkg::ST_R_UPD;
            swal_pkg::ST_R_UPD: n_state = swal_pkg::ST_L_CHK;
            swal_pkg::ST_L_CHK: begin
                priority if (i_stat.covered_all) begin
                    n_state = swal_pkg::ST_L_RD;
                end else if (i_stat.right_at_end) begin
                    n_state = swal_pkg::ST_IDLE;
                end else begin
                    n_state = swal_pkg::ST_R_RD;
                end
            end
            swal_pkg::ST_L_RD:  n_state = swal_pkg::ST_L_UPD;
            swal_pkg::ST_L_UPD: n_state = swal_pkg::ST_L_CHK;
            default:            n_state = swal_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = swal_pkg::OP_NONE;
        o_busy   = (r_state != swal_pkg::ST_IDLE);
        unique case (r_state)
            swal_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.op = swal_pkg::OP_LOAD;
                end
            end
            swal_pkg::ST_INIT: begin
                o_cmd.op = i_stat.len_zero ? swal_pkg::OP_FINISH : swal_pkg::OP_SCAN_INIT;
            end
            swal_pkg::ST_R_RD:  o_cmd.op = swal_pkg::OP_RD_RIGHT;
            swal_pkg::ST_R_CNT: o_cmd.op = swal_pkg::OP_RD_CNT;
            swal_pkg::ST_R_UPD: o_cmd.op = swal_pkg::OP_INC;
            swal_pkg::ST_L_CHK: begin
                priority if (i_stat.covered_all) begin
                    o_cmd.op = swal_pkg::OP_SHRINK;
                end else if (i_stat.right_at_end) begin
                    o_cmd.op = swal_pkg::OP_FINISH;
                end else begin
                    o_cmd.op = swal_pkg::OP_NEXT_R;
                end
            end
            swal_pkg::ST_L_RD:  o_cmd.op = swal_pkg::OP_RD_CNT;
            swal_pkg::ST_L_UPD: o_cmd.op = swal_pkg::OP_DEC;
            default:            o_cmd.op = swal_pkg::OP_NONE;
        endcase
    end

endmodule

// ----- src/swal_dp.sv -----
// Datapath for the shortest all-letters window block: letter store,
// per-letter count memory, pointers and result register; uses swal_pkg.
`timescale 1ns / 1ps

module swal_dp #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  swal_pkg::t_dp_cmd                i_cmd,
    input  logic [swal_pkg::LETTER_W-1:0]    i_letter,
    input  logic                             i_no_letter,
    output swal_pkg::t_dp_stat               o_stat,
    output logic                             o_valid,
    output logic [swal_pkg::OUT_LEN_W-1:0]   o_shortest_length,
    output logic                             o_overflow
);

    localparam int LENW = $clog2(MAX_LEN + 1);
    localparam int AW   = $clog2(MAX_LEN);
    localparam int LW   = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
    localparam int XW   = (LW > swal_pkg::LETTER_W) ? LW : swal_pkg::LETTER_W;
    localparam int DW   = $clog2(ALPHABET + 1);

    logic [LW-1:0]       r_text_mem [MAX_LEN];
    logic [LENW-1:0]     r_cnt_mem  [ALPHABET];

    logic [LW-1:0]       r_text_q;
    logic [LENW-1:0]     r_cnt_q;
    logic                r_cnt_vq;
    logic [LW-1:0]       r_addr;

    logic [LENW-1:0]     r_len,     n_len;
    logic                r_ovf,     n_ovf;
    logic [ALPHABET-1:0] r_needed,  n_needed;
    logic [ALPHABET-1:0] r_cnt_ok,  n_cnt_ok;
    logic [DW-1:0]       r_distinct, n_distinct;
    logic [DW-1:0]       r_covered, n_covered;
    logic [LENW-1:0]     r_left,    n_left;
    logic [LENW-1:0]     r_right,   n_right;
    logic [LENW-1:0]     r_best,    n_best;
    logic                r_out_v,   n_out_v;
    logic [LENW-1:0]     r_out_len, n_out_len;
    logic                r_out_ovf, n_out_ovf;

    logic [XW-1:0]       letter_x;
    logic [LW-1:0]       letter_idx;
    logic                letter_ok;
    logic [LENW-1:0]     cur_cnt;
    logic [LENW-1:0]     win_len;
    logic                txt_we;
    logic                txt_rd;
    logic [AW-1:0]       txt_raddr;
    logic                cnt_we;
    logic [LENW-1:0]     cnt_wdata;

    assign letter_x   = XW'(i_letter);
    assign letter_idx = letter_x[LW-1:0];
    assign letter_ok  = !i_no_letter && (letter_x < XW'(ALPHABET));
    // A count whose entry was not touched in this string reads as zero.
    assign cur_cnt    = r_cnt_vq ? r_cnt_q : '0;
    assign win_len    = r_right - r_left + LENW'(1);

    assign o_stat.len_zero     = (r_len == '0);
    assign o_stat.covered_all  = (r_covered == r_distinct) && (r_left <= r_right);
    assign o_stat.right_at_end = ((r_right + LENW'(1)) == r_len);

    assign txt_we    = (i_cmd.op == swal_pkg::OP_LOAD) && letter_ok
                       && (r_len != LENW'(MAX_LEN));
    assign txt_rd    = (i_cmd.op == swal_pkg::OP_RD_RIGHT) || (i_cmd.op == swal_pkg::OP_SHRINK);
    assign txt_raddr = (i_cmd.op == swal_pkg::OP_SHRINK) ? r_left[AW-1:0] : r_right[AW-1:0];
    assign cnt_we    = (i_cmd.op == swal_pkg::OP_INC) || (i_cmd.op == swal_pkg::OP_DEC);
    assign cnt_wdata = (i_cmd.op == swal_pkg::OP_INC) ? cur_cnt + LENW'(1)
                                                     : cur_cnt - LENW'(1);

    always_ff @(posedge i_clk) begin
        if (txt_we) begin
            r_text_mem[r_len[AW-1:0]] <= letter_idx;
        end
        if (txt_rd) begin
            r_text_q <= r_text_mem[txt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[r_addr] <= cnt_wdata;
        end
        if (i_cmd.op == swal_pkg::OP_RD_CNT) begin
            r_addr   <= r_text_q;
            r_cnt_q  <= r_cnt_mem[r_text_q];
            r_cnt_vq <= r_cnt_ok[r_text_q];
        end
    end

    always_comb begin
        n_len      = r_len;
        n_ovf      = r_ovf;
        n_needed   = r_needed;
        n_cnt_ok   = r_cnt_ok;
        n_distinct = r_distinct;
        n_covered  = r_covered;
        n_left     = r_left;
        n_right    = r_right;
        n_best     = r_best;
        n_out_v    = 1'b0;
        n_out_len  = r_out_len;
        n_out_ovf  = r_out_ovf;
        unique case (i_cmd.op)
            swal_pkg::OP_LOAD: begin
                if (letter_ok) begin
                    if (r_len != LENW'(MAX_LEN)) begin
                        n_len = r_len + LENW'(1);
                        if (!r_needed[letter_idx]) begin
                            n_needed[letter_idx] = 1'b1;
                            n_distinct = r_distinct + DW'(1);
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            swal_pkg::OP_SCAN_INIT: begin
                n_left  = '0;
                n_right = '0;
                n_best  = r_len;
            end
            swal_pkg::OP_INC: begin
                n_cnt_ok[r_addr] = 1'b1;
                if (cur_cnt == '0) begin
                    n_covered = r_covered + DW'(1);
                end
            end
            swal_pkg::OP_SHRINK: begin
                if (win_len < r_best) begin
                    n_best = win_len;
                end
            end
            swal_pkg::OP_DEC: begin
                if (cnt_wdata == '0) begin
                    n_covered = r_covered - DW'(1);
                end
                n_left = r_left + LENW'(1);
            end
            swal_pkg::OP_NEXT_R: begin
                n_right = r_right + LENW'(1);
            end
            swal_pkg::OP_FINISH: begin
                n_out_v    = 1'b1;
                n_out_len  = (r_len == '0) ? '0 : r_best;
                n_out_ovf  = r_ovf;
                // Return to the empty-string state for the next word.
                n_len      = '0;
                n_ovf      = 1'b0;
                n_needed   = '0;
                n_cnt_ok   = '0;
                n_distinct = '0;
                n_covered  = '0;
                n_left     = '0;
                n_right    = '0;
                n_best     = '0;
            end
            swal_pkg::OP_NONE, swal_pkg::OP_RD_RIGHT, swal_pkg::OP_RD_CNT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_needed   <= '0;
            r_cnt_ok   <= '0;
            r_distinct <= '0;
            r_covered  <= '0;
            r_left     <= '0;
            r_right    <= '0;
            r_best     <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_ovf      <= n_ovf;
            r_needed   <= n_needed;
            r_cnt_ok   <= n_cnt_ok;
            r_distinct <= n_distinct;
            r_covered  <= n_covered;
            r_left     <= n_left;
            r_right    <= n_right;
            r_best     <= n_best;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_len <= n_out_len;
        r_out_ovf <= n_out_ovf;
    end

    assign o_valid           = r_out_v;
    assign o_shortest_length = swal_pkg::OUT_LEN_W'(r_out_len);
    assign o_overflow        = r_out_ovf;

endmodule

// ----- src/shortest_window_all_letters_core.sv -----
// Top level of the shortest all-letters window block.
// Joins swal_ctrl and swal_dp; uses swal_pkg.
`timescale 1ns / 1ps

// A string arrives one word per accepted start (start high, busy low), one
// letter index per word; a word with i_no_letter set carries no letter, and
// i_is_last closes the string; any other word leaves the block idle, ready
// for the next word. After the last word the block scans the stored string
// with two pointers, a right-pointer step through ST_R_RD, ST_R_CNT, ST_R_UPD
// and ST_L_CHK, a left-pointer step through ST_L_CHK, ST_L_RD and ST_L_UPD, as
// the letter store and the per-letter count memory each have a single read
// port. The result is shown for exactly one cycle with o_valid high; it cannot
// be held off, so the receiver must take it then. Letters past MAX_LEN are
// dropped and flagged through o_overflow.
module shortest_window_all_letters_core #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [swal_pkg::LETTER_W-1:0]  i_letter,
    input  logic                           i_is_last,
    input  logic                           i_no_letter,
    output logic                           o_valid,
    output logic [swal_pkg::OUT_LEN_W-1:0] o_shortest_length,
    output logic                           o_overflow
);

    swal_pkg::t_dp_cmd  cmd;
    swal_pkg::t_dp_stat stat;

    swal_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_is_last (i_is_last),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    swal_dp #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_letter          (i_letter),
        .i_no_letter       (i_no_letter),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_shortest_length (o_shortest_length),
        .o_overflow        (o_overflow)
    );

endmodule

// ----- src/swal_checker.sv -----
// Port-level checker for the shortest all-letters window block,
// bound to shortest_window_all_letters_core; uses swal_pkg widths.
`timescale 1ns / 1ps

module swal_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           i_is_last,
    input logic                           o_valid,
    input logic [swal_pkg::OUT_LEN_W-1:0] o_shortest_length
);

    // A result only ever closes a scan, so busy was high the cycle before.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word without a preceding scan");

    // Results are single-cycle pulses.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // A closing word starts the scan at once.
    a_last_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_is_last) |=> busy)
        else $error("last word accepted but block not busy");

    // Any other word leaves the block idle, with no result shown, in the next cycle.
    a_letter_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_is_last) |=> (!busy && !o_valid))
        else $error("plain word did not complete in one cycle");

    // A shown result always carries a defined length.
    a_length_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_shortest_length))
        else $error("result word with an unknown length");

endmodule

bind shortest_window_all_letters_core swal_checker u_swal_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_is_last         (i_is_last),
    .o_valid           (o_valid),
    .o_shortest_length (o_shortest_length)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for shortest_window_all_letters_core.
// Sends strings word by word, predicts each shortest covering window length
// and overflow flag, and checks every result. Depends on src/swal_pkg.sv.
`timescale 1ns / 1ps

module tb_top;

    localparam int LETTERS      = 26;
    localparam int STORE_DEPTH  = 1024;
    localparam int MAX_GAP      = 13;
    localparam int RANDOM_WORDS = 400;
    localparam int STALL_LIMIT  = 30000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [swal_pkg::OUT_LEN_W-1:0] length;
        logic                           overflow;
    } t_window_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [swal_pkg::LETTER_W-1:0]  i_letter;
    logic                           i_is_last;
    logic                           i_no_letter;
    logic                           o_valid;
    logic [swal_pkg::OUT_LEN_W-1:0] o_shortest_length;
    logic                           o_overflow;

    // Predictor state: the letters stored so far and which letters occur.
    logic [swal_pkg::LETTER_W-1:0] stored_letters[$];
    logic [LETTERS-1:0]            letters_present;
    logic                          letters_dropped;
    t_window_result                expected_windows[$];

    int  mismatch_count;
    int  words_accepted;
    int  strings_checked;
    int  overflow_strings;
    int  longest_result;
    int  stall_cycles;
    bit  burst_mode;

    shortest_window_all_letters_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_letter         (i_letter),
        .i_is_last        (i_is_last),
        .i_no_letter      (i_no_letter),
        .o_valid          (o_valid),
        .o_shortest_length(o_shortest_length),
        .o_overflow       (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Two-pointer search over the stored string for the shortest span that
    // holds every letter present.
    function automatic logic [swal_pkg::OUT_LEN_W-1:0] shortest_cover();
        int tally[LETTERS];
        int need;
        int have;
        int lo;
        int best;
        int n;
        int c;
        n = stored_letters.size();
        if (n == 0) begin
            return '0;
        end
        foreach (tally[k]) tally[k] = 0;
        need = $countones(letters_present);
        have = 0;
        lo   = 0;
        best = n;
        for (int hi = 0; hi < n; hi++) begin
            c = stored_letters[hi];
            if (tally[c] == 0) have++;
            tally[c]++;
            while (have == need && lo <= hi) begin
                if (hi - lo + 1 < best) best = hi - lo + 1;
                c = stored_letters[lo];
                tally[c]--;
                if (tally[c] == 0) have--;
                lo++;
            end
        end
        return best[swal_pkg::OUT_LEN_W-1:0];
    endfunction

    task automatic apply_word(input logic [4:0] letter, input logic last, input logic none);
        t_window_result res;
        if (!none && letter < LETTERS) begin
            if (stored_letters.size() < STORE_DEPTH) begin
                stored_letters.push_back(letter);
                letters_present[letter] = 1'b1;
            end else begin
                letters_dropped = 1'b1;
            end
        end
        if (last) begin
            res.length   = shortest_cover();
            res.overflow = letters_dropped;
            expected_windows.push_back(res);
            stored_letters.delete();
            letters_present = '0;
            letters_dropped = 1'b0;
        end
    endtask

    // Drives one word after a random gap (none in burst mode) and waits until the block takes it.
    task automatic send_word(input logic [4:0] letter, input logic last, input logic none);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start       <= 1'b1;
        i_letter    <= letter;
        i_is_last   <= last;
        i_no_letter <= none;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        words_accepted++;
        apply_word(letter, last, none);
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_windows.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_special_cases();
        burst_mode = 1'b0;
        send_word(5'd0, 1'b1, 1'b1);            // empty string
        send_word(5'd31, 1'b0, 1'b1);           // carries no letter, not last
        send_word(5'd25, 1'b1, 1'b0);           // letter on the last word
        send_word(5'd28, 1'b1, 1'b0);           // only a dropped letter: empty
        send_word(5'd0, 1'b0, 1'b0);
        send_word(5'd0, 1'b0, 1'b0);
        send_word(5'd0, 1'b1, 1'b0);
        pause_until_drained();
        burst_mode = 1'b1;
        send_word(5'd1, 1'b0, 1'b0);
        send_word(5'd31, 1'b0, 1'b0);
        send_word(5'd2, 1'b0, 1'b0);
        send_word(5'd5, 1'b1, 1'b1);            // no letter closes a stored string
        burst_mode = 1'b0;
        send_word(5'd0, 1'b0, 1'b0);
        send_word(5'd1, 1'b0, 1'b0);
        send_word(5'd1, 1'b0, 1'b0);
        send_word(5'd0, 1'b0, 1'b0);
        send_word(5'd2, 1'b1, 1'b0);
        send_word(5'd25, 1'b0, 1'b0);
        send_word(5'd0, 1'b0, 1'b0);
        send_word(5'd26, 1'b0, 1'b0);
        send_word(5'd25, 1'b0, 1'b0);
        send_word(5'd0, 1'b1, 1'b0);
    endtask

    // Fills the store exactly with a full-length window, then overfills it.
    task automatic test_capacity();
        burst_mode = 1'b0;
        send_word(5'd0, 1'b0, 1'b0);
        for (int i = 0; i < STORE_DEPTH - 2; i++) send_word(5'd2, 1'b0, 1'b0);
        send_word(5'd1, 1'b0, 1'b0);
        send_word(5'd25, 1'b0, 1'b0);
        send_word(5'd31, 1'b0, 1'b0);
        send_word(5'd7, 1'b1, 1'b0);
    endtask

    // Strings over a small run of letters, with stray words mixed in.
    task automatic send_random_string(inout int counted);
        int  span;
        int  base;
        int  n;
        bit  tail_none;
        logic [4:0] ltr;
        burst_mode = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 19) == 0) begin
            send_word(5'($urandom_range(0, 31)), 1'b1, 1'b1);
            counted++;
            return;
        end
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, LETTERS) : $urandom_range(1, 5);
        base = $urandom_range(0, LETTERS - span);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
        tail_none = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_word(5'($urandom_range(0, 31)), 1'b0, 1'b1);
                end else begin
                    send_word(5'($urandom_range(LETTERS, 31)), 1'b0, 1'b0);
                end
            end
            ltr = 5'(base + $urandom_range(0, span - 1));
            send_word(ltr, (i == n - 1) && !tail_none, 1'b0);
            counted++;
        end
        if (tail_none) begin
            send_word(5'($urandom_range(0, 31)), 1'b1, 1'b1);
            counted++;
        end
    endtask

    task automatic test_random_strings();
        int counted;
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            if ($urandom_range(0, 24) == 0) pause_until_drained();
            send_random_string(counted);
        end
    endtask

    always @(posedge i_clk) begin
        t_window_result exp_res;
        if (i_rst_n && o_valid) begin
            if (expected_windows.size() == 0) begin
                $display("%0t: expected no result, actual length %0d overflow %0b",
                         $time, o_shortest_length, o_overflow);
                mismatch_count++;
            end else begin
                exp_res = expected_windows.pop_front();
                strings_checked++;
                if (exp_res.overflow) overflow_strings++;
                if (exp_res.length > longest_result) longest_result = exp_res.length;
                if (o_shortest_length !== exp_res.length) begin
                    $display("%0t: length expected %0d, actual %0d",
                             $time, exp_res.length, o_shortest_length);
                    mismatch_count++;
                end
                if (o_overflow !== exp_res.overflow) begin
                    $display("%0t: overflow expected %0b, actual %0b",
                             $time, exp_res.overflow, o_overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if neither a word nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, nothing moved for %0d cycles", $time, stall_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        start            = 1'b0;
        i_letter         = '0;
        i_is_last        = 1'b0;
        i_no_letter      = 1'b0;
        i_rst_n          = 1'b0;
        letters_present  = '0;
        letters_dropped  = 1'b0;
        mismatch_count   = 0;
        words_accepted   = 0;
        strings_checked  = 0;
        overflow_strings = 0;
        longest_result   = 0;
        stall_cycles     = 0;
        burst_mode       = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_capacity();
        test_random_strings();

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_windows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d words in %0d strings, %0d of them overflowing the store.",
                 words_accepted, strings_checked, overflow_strings);
        $display("Longest expected window was %0d letters.", longest_result);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/swal_pkg.sv
src/swal_ctrl.sv
src/swal_dp.sv
src/shortest_window_all_letters_core.sv
src/swal_checker.sv
tb/tb_top.sv
